// ===== sv/tbs_pkg.sv =====
// Types, constants and byte-class helpers for the text block segmenter.
package tbs_pkg;

    localparam int SPAN_DEPTH_DEF = 16;
    localparam int WS_DEPTH_DEF   = 16;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_EXCL   = 8'h21;

    localparam logic [7:0] UTF_LEAD  = 8'hE2;
    localparam logic [7:0] UTF_MID   = 8'h80;
    localparam logic [7:0] UTF_EN    = 8'h93;
    localparam logic [7:0] UTF_EM    = 8'h94;

    // held mark kinds
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_DASH  = 2'd1;
    localparam logic [1:0] PEND_PUNCT = 2'd2;

    // multibyte dash progress; OWE_MID means 0x80 still has to go out
    localparam logic [1:0] DP_NONE    = 2'd0;
    localparam logic [1:0] DP_LEAD    = 2'd1;
    localparam logic [1:0] DP_MID     = 2'd2;
    localparam logic [1:0] DP_OWE_MID = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       block_end;
        logic       overflow;
        logic       last_result;
    } t_out;

    typedef enum logic [1:0] {
        CONT_PROC = 2'd0,
        CONT_DUMP = 2'd1,
        CONT_DONE = 2'd2
    } t_cont;

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic is_closer(input logic [7:0] b);
        return b == CH_RPAREN || b == CH_RBRACK || b == CH_RBRACE ||
               b == CH_DQUOTE || b == CH_SQUOTE;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b == CH_PERIOD || b == CH_COMMA || b == CH_COLON ||
               b == CH_SEMI || b == CH_QUEST || b == CH_EXCL;
    endfunction

    function automatic logic is_opener(input logic [7:0] b);
        return b == CH_LPAREN || b == CH_LBRACK || b == CH_LBRACE;
    endfunction

    function automatic logic [7:0] closer_of(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_LPAREN: r = CH_RPAREN;
            CH_LBRACK: r = CH_RBRACK;
            default:   r = CH_RBRACE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] opener_of(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_RPAREN: r = CH_LPAREN;
            CH_RBRACK: r = CH_LBRACK;
            default:   r = CH_LBRACE;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/text_block_segmenter_unit.sv =====
// Text block segmenter: byte sequencer over span and leading-whitespace memories.
// One input byte is taken in idle; the input stays stalled until that byte is done, and each byte
// it emits, each flushed whitespace byte and each span byte emitted on a match or replayed
// adds to that time (memory reads are registered).
// Results leave through a hold stage and an output register, so last_result is known.
// Synchronous active-low reset clears the control state; the buffers are not cleared.
module text_block_segmenter_unit
    import tbs_pkg::*;
#(
    parameter int SPAN_DEPTH       = SPAN_DEPTH_DEF,
    parameter int WHITESPACE_DEPTH = WS_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int SCW = $clog2(SPAN_DEPTH + 1);
    localparam int SAW = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
    localparam int WCW = $clog2(WHITESPACE_DEPTH + 1);
    localparam int WAW = (WHITESPACE_DEPTH > 1) ? $clog2(WHITESPACE_DEPTH) : 1;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_PROC = 14'b00000000000010,
        S_EMIT = 14'b00000000000100,
        S_WRD  = 14'b00000000001000,
        S_WPUT = 14'b00000000010000,
        S_DCHK = 14'b00000000100000,
        S_DRD  = 14'b00000001000000,
        S_DLD  = 14'b00000010000000,
        S_NEXT = 14'b00000100000000,
        S_RRD  = 14'b00001000000000,
        S_RLD  = 14'b00010000000000,
        S_END  = 14'b00100000000000,
        S_OVF  = 14'b01000000000000,
        S_FIN  = 14'b10000000000000
    } t_state;

    logic [7:0] span_mem [SPAN_DEPTH];
    logic [7:0] ws_mem   [WHITESPACE_DEPTH];

    t_state     r_state, n_state;
    logic [7:0] r_prev, n_prev;
    logic       r_at_start, n_at_start;
    logic [7:0] r_held, n_held;
    logic [1:0] r_pend, n_pend;
    logic [1:0] r_prog, n_prog;
    logic [SCW-1:0] r_sp_cnt, n_sp_cnt;
    logic [7:0] r_closer, n_closer;
    logic [WCW-1:0] r_wcnt, n_wcnt;
    logic       r_has, n_has;
    logic [7:0] r_in_b, n_in_b;
    logic       r_in_last, n_in_last;
    logic [7:0] r_cb, n_cb;
    logic       r_cps, n_cps;
    logic       r_clast, n_clast;
    logic [7:0] r_ex, n_ex;
    t_cont      r_cont, n_cont;
    logic       r_ovf, n_ovf;
    logic       r_rp_act, n_rp_act;
    logic [SCW-1:0] r_rp_len, n_rp_len;
    logic [SCW-1:0] r_rp_idx, n_rp_idx;
    logic [7:0] r_term_b, n_term_b;
    logic       r_term_last, n_term_last;
    logic [SCW-1:0] r_d_idx, n_d_idx;
    logic [WCW-1:0] r_w_idx, n_w_idx;
    logic       r_oval, n_oval;
    t_out       r_out, n_out;
    logic       r_pv, n_pv;
    t_out       r_p, n_p;

    logic [7:0] r_sp_q, r_ws_q;
    logic [SAW-1:0] sp_ra, sp_wa;
    logic [7:0] sp_wd;
    logic       sp_we;
    logic [WAW-1:0] ws_wa;
    logic [7:0] ws_wd;
    logic       ws_we;

    logic out_free, can_put, eb_go;
    logic put_en, fin_en;
    t_out put_d;

    assign out_free = !r_oval || !i_stall;
    assign can_put  = !r_pv || out_free;
    assign eb_go    = !r_has || can_put;
    assign sp_ra    = (r_state == S_DRD) ? r_d_idx[SAW-1:0] : r_rp_idx[SAW-1:0];

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;     n_prev = r_prev;         n_at_start = r_at_start;
        n_held = r_held;       n_pend = r_pend;         n_prog = r_prog;
        n_sp_cnt = r_sp_cnt;   n_closer = r_closer;     n_wcnt = r_wcnt;
        n_has = r_has;         n_in_b = r_in_b;         n_in_last = r_in_last;
        n_cb = r_cb;           n_cps = r_cps;           n_clast = r_clast;
        n_ex = r_ex;           n_cont = r_cont;         n_ovf = r_ovf;
        n_rp_act = r_rp_act;   n_rp_len = r_rp_len;     n_rp_idx = r_rp_idx;
        n_term_b = r_term_b;   n_term_last = r_term_last;
        n_d_idx = r_d_idx;     n_w_idx = r_w_idx;
        put_en = 1'b0;
        fin_en = 1'b0;
        put_d  = '{out_byte: 8'h00, block_end: 1'b0, overflow: 1'b0, last_result: 1'b0};
        sp_we = 1'b0;
        sp_wa = r_sp_cnt[SAW-1:0];
        sp_wd = r_cb;
        ws_we = 1'b0;
        ws_wa = r_wcnt[WAW-1:0];
        ws_wd = r_ex;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in_b    = i_data.text_byte;
                    n_in_last = i_data.end_of_text;
                    n_cb      = i_data.text_byte;
                    n_cps     = r_at_start || r_prev == CH_SPACE;
                    n_clast   = i_data.end_of_text;
                    n_ovf     = 1'b0;
                    n_rp_act  = 1'b0;
                    n_state   = S_PROC;
                end
            end
            S_PROC: begin
                if (r_closer != 8'h00) begin
                    if (r_cb == CH_SPACE || (r_cb != r_closer &&
                            (r_clast || r_sp_cnt == SCW'(SPAN_DEPTH)))) begin
                        // unmatched opener: run its span bytes again, then this byte
                        if (r_cb != CH_SPACE && !r_clast) n_ovf = 1'b1;
                        n_rp_act    = 1'b1;
                        n_rp_len    = r_sp_cnt;
                        n_rp_idx    = '0;
                        n_term_b    = r_cb;
                        n_term_last = r_clast;
                        n_closer    = 8'h00;
                        n_sp_cnt    = '0;
                        n_state     = S_NEXT;
                    end else if (r_cb == r_closer) begin
                        n_ex    = opener_of(r_closer);
                        n_cont  = CONT_DUMP;
                        n_d_idx = '0;
                        n_state = S_EMIT;
                    end else begin
                        sp_we    = 1'b1;
                        n_sp_cnt = r_sp_cnt + SCW'(1);
                        n_state  = S_NEXT;
                    end
                end else if (r_pend != PEND_NONE) begin
                    if (r_cb == CH_SPACE || (r_pend == PEND_PUNCT &&
                            (r_cb == CH_DQUOTE || r_cb == CH_SQUOTE))) begin
                        if (eb_go) begin
                            if (r_has) begin
                                put_en = 1'b1;
                                put_d.block_end = 1'b1;
                            end
                            n_has   = 1'b0;
                            n_wcnt  = '0;
                            n_pend  = PEND_NONE;
                            n_state = S_NEXT;
                        end
                    end else begin
                        n_ex    = (r_pend == PEND_DASH) ? CH_DASH : r_held;
                        n_pend  = PEND_NONE;
                        n_held  = 8'h00;
                        n_cont  = CONT_PROC;
                        n_state = S_EMIT;
                    end
                end else if (r_prog == DP_LEAD) begin
                    if (r_cb == UTF_MID && !r_clast) begin
                        n_prog  = DP_MID;
                        n_state = S_NEXT;
                    end else begin
                        n_prog  = DP_NONE;
                        n_ex    = UTF_LEAD;
                        n_cont  = CONT_PROC;
                        n_state = S_EMIT;
                    end
                end else if (r_prog == DP_MID) begin
                    if (r_cb == UTF_EN || r_cb == UTF_EM) begin
                        n_prog  = DP_NONE;
                        n_state = S_NEXT;
                    end else begin
                        n_prog  = DP_OWE_MID;
                        n_ex    = UTF_LEAD;
                        n_cont  = CONT_PROC;
                        n_state = S_EMIT;
                    end
                end else if (r_prog == DP_OWE_MID) begin
                    n_prog  = DP_NONE;
                    n_ex    = UTF_MID;
                    n_cont  = CONT_PROC;
                    n_state = S_EMIT;
                end else if (r_cb == UTF_LEAD && !r_clast) begin
                    n_prog  = DP_LEAD;
                    n_state = S_NEXT;
                end else if ((r_cb == CH_DASH && r_cps && !r_clast) ||
                             (is_punct(r_cb) && !r_clast)) begin
                    n_pend  = (r_cb == CH_DASH) ? PEND_DASH : PEND_PUNCT;
                    n_held  = r_cb;
                    n_state = S_NEXT;
                end else if ((r_cb == CH_DASH && r_cps) || is_closer(r_cb) ||
                             is_punct(r_cb)) begin
                    if (eb_go) begin
                        if (r_has) begin
                            put_en = 1'b1;
                            put_d.block_end = 1'b1;
                        end
                        n_has   = 1'b0;
                        n_wcnt  = '0;
                        n_state = S_NEXT;
                    end
                end else if (is_opener(r_cb)) begin
                    // an opener as the final byte is dropped
                    if (!r_clast) begin
                        n_closer = closer_of(r_cb);
                        n_sp_cnt = '0;
                    end
                    n_state = S_NEXT;
                end else begin
                    n_ex    = r_cb;
                    n_cont  = CONT_DONE;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_has) begin
                    if (can_put) begin
                        put_en = 1'b1;
                        put_d.out_byte = r_ex;
                        n_state = (r_cont == CONT_PROC) ? S_PROC :
                                  (r_cont == CONT_DUMP) ? S_DCHK : S_NEXT;
                    end
                end else if (is_ws(r_ex)) begin
                    // hold leading whitespace until the block shows text
                    if (r_wcnt < WCW'(WHITESPACE_DEPTH)) begin
                        ws_we  = 1'b1;
                        n_wcnt = r_wcnt + WCW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = (r_cont == CONT_PROC) ? S_PROC :
                              (r_cont == CONT_DUMP) ? S_DCHK : S_NEXT;
                end else if (r_wcnt != '0) begin
                    n_w_idx = '0;
                    n_state = S_WRD;
                end else if (can_put) begin
                    put_en = 1'b1;
                    put_d.out_byte = r_ex;
                    n_has = 1'b1;
                    n_state = (r_cont == CONT_PROC) ? S_PROC :
                              (r_cont == CONT_DUMP) ? S_DCHK : S_NEXT;
                end
            end
            S_WRD: begin
                n_state = S_WPUT;
            end
            S_WPUT: begin
                if (can_put) begin
                    put_en = 1'b1;
                    put_d.out_byte = r_ws_q;
                    if (r_w_idx + WCW'(1) == r_wcnt) begin
                        n_wcnt  = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_w_idx = r_w_idx + WCW'(1);
                        n_state = S_WRD;
                    end
                end
            end
            S_DCHK: begin
                if (r_d_idx < r_sp_cnt) begin
                    n_state = S_DRD;
                end else begin
                    n_ex     = r_cb;
                    n_closer = 8'h00;
                    n_sp_cnt = '0;
                    n_cont   = CONT_DONE;
                    n_state  = S_EMIT;
                end
            end
            S_DRD: begin
                n_state = S_DLD;
            end
            S_DLD: begin
                n_ex    = r_sp_q;
                n_d_idx = r_d_idx + SCW'(1);
                n_cont  = CONT_DUMP;
                n_state = S_EMIT;
            end
            S_NEXT: begin
                if (!r_rp_act) begin
                    n_state = S_END;
                end else if (r_rp_idx < r_rp_len) begin
                    n_state = S_RRD;
                end else begin
                    n_rp_act = 1'b0;
                    n_cb     = r_term_b;
                    n_cps    = 1'b0;
                    n_clast  = r_term_last;
                    n_state  = S_PROC;
                end
            end
            S_RRD: begin
                n_state = S_RLD;
            end
            S_RLD: begin
                n_cb     = r_sp_q;
                n_cps    = 1'b0;
                n_clast  = 1'b0;
                n_rp_idx = r_rp_idx + SCW'(1);
                n_state  = S_PROC;
            end
            S_END: begin
                if (!r_in_last) begin
                    n_prev     = r_in_b;
                    n_at_start = 1'b0;
                    n_state    = S_OVF;
                end else if (eb_go) begin
                    if (r_has) begin
                        put_en = 1'b1;
                        put_d.block_end = 1'b1;
                    end
                    n_has      = 1'b0;
                    n_wcnt     = '0;
                    n_at_start = 1'b1;
                    n_prev     = 8'h00;
                    n_pend     = PEND_NONE;
                    n_held     = 8'h00;
                    n_prog     = DP_NONE;
                    n_closer   = 8'h00;
                    n_sp_cnt   = '0;
                    n_state    = S_OVF;
                end
            end
            S_OVF: begin
                if (!r_ovf) begin
                    n_state = S_FIN;
                end else if (can_put) begin
                    put_en = 1'b1;
                    put_d.overflow = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    fin_en  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hold stage: a result waits there until the next one shows it was not the last
        n_oval = r_oval && i_stall;
        n_out  = r_out;
        n_pv   = r_pv;
        n_p    = r_p;
        if (put_en) begin
            if (r_pv) begin
                n_oval = 1'b1;
                n_out  = r_p;
            end
            n_pv = 1'b1;
            n_p  = put_d;
        end
        if (fin_en) begin
            n_oval = 1'b1;
            n_out  = r_p;
            n_out.last_result = 1'b1;
            n_pv   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sp_we) span_mem[sp_wa] <= sp_wd;
        r_sp_q <= span_mem[sp_ra];
        if (ws_we) ws_mem[ws_wa] <= ws_wd;
        r_ws_q <= ws_mem[r_w_idx[WAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev     <= 8'h00;
            r_at_start <= 1'b1;
            r_held     <= 8'h00;
            r_pend     <= PEND_NONE;
            r_prog     <= DP_NONE;
            r_sp_cnt   <= '0;
            r_closer   <= 8'h00;
            r_wcnt     <= '0;
            r_has      <= 1'b0;
            r_ovf      <= 1'b0;
            r_rp_act   <= 1'b0;
            r_oval     <= 1'b0;
            r_pv       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prev     <= n_prev;
            r_at_start <= n_at_start;
            r_held     <= n_held;
            r_pend     <= n_pend;
            r_prog     <= n_prog;
            r_sp_cnt   <= n_sp_cnt;
            r_closer   <= n_closer;
            r_wcnt     <= n_wcnt;
            r_has      <= n_has;
            r_ovf      <= n_ovf;
            r_rp_act   <= n_rp_act;
            r_oval     <= n_oval;
            r_pv       <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_b      <= n_in_b;
        r_in_last   <= n_in_last;
        r_cb        <= n_cb;
        r_cps       <= n_cps;
        r_clast     <= n_clast;
        r_ex        <= n_ex;
        r_cont      <= n_cont;
        r_rp_len    <= n_rp_len;
        r_rp_idx    <= n_rp_idx;
        r_term_b    <= n_term_b;
        r_term_last <= n_term_last;
        r_d_idx     <= n_d_idx;
        r_w_idx     <= n_w_idx;
        r_out       <= n_out;
        r_p         <= n_p;
    end

endmodule
